[hw/rtl/shd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package shd_pkg;

    // Opcodes of an input request.
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_OPEN  = 2'd1;
    localparam logic [1:0] OP_CLOSE = 2'd2;
    localparam logic [1:0] OP_QUERY = 2'd3;

    // Run modes.
    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_OPENING = 2'd1;
    localparam logic [1:0] MODE_CLOSING = 2'd2;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_DURATION   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REVOLUTION_LIM  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PER_REV   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_CLOCKWISE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_CLOCKWISE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TABLE     = 3'd5;

    localparam int unsigned CFG_DATA_W = 32;

    // Register reset values.
    localparam logic [9:0]  RST_FULL_DURATION  = 10'd60;
    localparam logic [7:0]  RST_REVOLUTION_LIM = 8'd12;
    localparam logic [15:0] RST_STEPS_PER_REV  = 16'd4096;
    localparam logic        RST_OPEN_CW        = 1'b0;
    localparam logic        RST_CLOSE_CW       = 1'b1;
    localparam logic [31:0] RST_PHASE_TABLE    = 32'h913264C8;

    localparam logic [9:0]  DURATION_MAX      = 10'd1000;
    localparam logic [9:0]  DURATION_FALLBACK = 10'd60;

    // The stop input is polled every POLL_EVERY steps of a revolution.
    localparam logic [6:0]  POLL_LAST = 7'd123;

    // 2^24 / 49.152, rounded up; exact floor for every duration up to 1000.
    localparam logic [18:0] DELAY_RECIP = 19'd341334;

    typedef struct packed {
        logic [1:0] opcode;
        logic       stop_level;
    } in_item_t;

    typedef struct packed {
        logic [3:0] coil_pattern;
        logic       busy_res;
        logic       accepted;
        logic       done_res;
        logic       stopped_early;
    } out_item_t;

    typedef struct packed {
        logic [7:0]  revolution_limit;
        logic [15:0] steps_per_revolution;
        logic        open_clockwise;
        logic        close_clockwise;
        logic [31:0] phase_table;
        logic [4:0]  delay_m1;
    } cfg_t;

    // Step delay in milliseconds minus one: max(1, floor(d * 1000 / 49152)) - 1.
    function automatic logic [4:0] delay_m1(input logic [9:0] duration);
        logic [9:0]  d;
        logic [28:0] prod;
        logic [4:0]  ms;
        d    = (duration > DURATION_MAX) ? DURATION_FALLBACK : duration;
        prod = {19'd0, d} * {10'd0, DELAY_RECIP};
        ms   = prod[28:24];
        if (ms == 5'd0)
        begin
            ms = 5'd1;
        end
        return ms - 5'd1;
    endfunction

    localparam logic [4:0] RST_DELAY_M1 = delay_m1(RST_FULL_DURATION);

endpackage

`default_nettype wire

[hw/rtl/stepper_halfstep_door_drive.sv]
`timescale 1ns / 1ps
`default_nettype none
// Requests pass the input register, then the result register, one request per cycle while
// no held-off result backs them up. The input register feeds the sequencer state update,
// which loads the result register, and both advance whenever the result register frees up.
// Reset (rst_n, asynchronous, active low) empties both stages, turns the coils off, leaves
// the drive idle and loads the configuration registers with their default values.

module stepper_halfstep_door_drive
    import shd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire in_item_t              in_item,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output out_item_t                  out_item,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic [7:0]  rev_lim_reg;
    logic [15:0] spr_reg;
    logic        open_cw_reg;
    logic        close_cw_reg;
    logic [31:0] phase_table_reg;
    logic [4:0]  delay_m1_reg;

    logic        s1_valid_reg;
    in_item_t    s1_item_reg;
    logic        out_valid_reg;
    out_item_t   out_item_reg;

    logic        out_free;
    logic        s1_advance;
    logic        in_take;
    cfg_t        cfg;
    out_item_t   seq_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rev_lim_reg     <= RST_REVOLUTION_LIM;
            spr_reg         <= RST_STEPS_PER_REV;
            open_cw_reg     <= RST_OPEN_CW;
            close_cw_reg    <= RST_CLOSE_CW;
            phase_table_reg <= RST_PHASE_TABLE;
            delay_m1_reg    <= RST_DELAY_M1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FULL_DURATION:   delay_m1_reg    <= delay_m1(cfg_data[9:0]);
                CFG_REVOLUTION_LIM:  rev_lim_reg     <= cfg_data[7:0];
                CFG_STEPS_PER_REV:   spr_reg         <= cfg_data[15:0];
                CFG_OPEN_CLOCKWISE:  open_cw_reg     <= cfg_data[0];
                CFG_CLOSE_CLOCKWISE: close_cw_reg    <= cfg_data[0];
                CFG_PHASE_TABLE:     phase_table_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        cfg.revolution_limit     = rev_lim_reg;
        cfg.steps_per_revolution = spr_reg;
        cfg.open_clockwise       = open_cw_reg;
        cfg.close_clockwise      = close_cw_reg;
        cfg.phase_table          = phase_table_reg;
        cfg.delay_m1             = delay_m1_reg;
    end

    assign out_free   = !out_valid_reg || !out_stall;
    assign s1_advance = s1_valid_reg && out_free;
    assign in_stall   = s1_valid_reg && !out_free;
    assign in_take    = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_item_reg <= in_item;
        end
    end

    shd_seq u_seq
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (s1_advance),
        .item    (s1_item_reg),
        .cfg     (cfg),
        .res     (seq_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_item_reg <= seq_res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire

[hw/rtl/shd_seq.sv]
`timescale 1ns / 1ps
`default_nettype none

module shd_seq
    import shd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      step_en,
    input  wire in_item_t  item,
    input  wire cfg_t      cfg,
    output out_item_t      res
);

    logic [2:0]  phase_reg, phase_next;
    logic        turn_cw_reg, turn_cw_next;
    logic [1:0]  mode_reg, mode_next;
    logic        pending_reg, pending_next;
    logic [15:0] step_reg, step_next;
    logic [6:0]  poll_reg, poll_next;
    logic [7:0]  revs_reg, revs_next;
    logic [4:0]  delay_left_reg, delay_left_next;
    logic [3:0]  coil_reg, coil_next;

    logic [16:0] step_inc;
    logic        acc;
    logic        done;
    logic        early;

    assign step_inc = {1'b0, step_reg} + 17'd1;

    always_comb
    begin
        phase_next      = phase_reg;
        turn_cw_next    = turn_cw_reg;
        mode_next       = mode_reg;
        pending_next    = pending_reg;
        step_next       = step_reg;
        poll_next       = poll_reg;
        revs_next       = revs_reg;
        delay_left_next = delay_left_reg;
        coil_next       = coil_reg;
        acc             = 1'b0;
        done            = 1'b0;
        early           = 1'b0;

        case (item.opcode)
            OP_OPEN, OP_CLOSE:
            begin
                if (mode_reg == MODE_IDLE)
                begin
                    turn_cw_next    = (item.opcode == OP_OPEN) ? cfg.open_clockwise
                                                               : cfg.close_clockwise;
                    mode_next       = (item.opcode == OP_OPEN) ? MODE_OPENING : MODE_CLOSING;
                    pending_next    = 1'b1;
                    step_next       = 16'd0;
                    poll_next       = 7'd0;
                    revs_next       = 8'd0;
                    delay_left_next = 5'd0;
                    acc             = 1'b1;
                end
            end
            OP_QUERY:
            begin
                if (!pending_reg)
                begin
                    done = 1'b1;
                end
                else if (mode_reg == MODE_IDLE)
                begin
                    pending_next = 1'b0;
                    done         = 1'b1;
                end
            end
            default:
            begin
                if (mode_reg != MODE_IDLE)
                begin
                    if (delay_left_reg != 5'd0)
                    begin
                        delay_left_next = delay_left_reg - 5'd1;
                    end
                    else if (revs_reg >= cfg.revolution_limit ||
                             cfg.steps_per_revolution == 16'd0)
                    begin
                        mode_next       = MODE_IDLE;
                        delay_left_next = 5'd0;
                    end
                    else
                    begin
                        // The coils show the pattern of the phase before it moves.
                        coil_next  = cfg.phase_table[{phase_reg, 2'b00} +: 4];
                        phase_next = turn_cw_reg ? phase_reg - 3'd1 : phase_reg + 3'd1;
                        if (poll_reg == 7'd0 && item.stop_level)
                        begin
                            early           = 1'b1;
                            mode_next       = MODE_IDLE;
                            delay_left_next = 5'd0;
                        end
                        else
                        begin
                            if (step_inc >= {1'b0, cfg.steps_per_revolution})
                            begin
                                step_next = 16'd0;
                                poll_next = 7'd0;
                                revs_next = revs_reg + 8'd1;
                            end
                            else
                            begin
                                step_next = step_inc[15:0];
                                poll_next = (poll_reg == POLL_LAST) ? 7'd0 : poll_reg + 7'd1;
                            end
                            delay_left_next = cfg.delay_m1;
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= 3'd0;
            turn_cw_reg    <= 1'b0;
            mode_reg       <= MODE_IDLE;
            pending_reg    <= 1'b0;
            step_reg       <= 16'd0;
            poll_reg       <= 7'd0;
            revs_reg       <= 8'd0;
            delay_left_reg <= 5'd0;
            coil_reg       <= 4'd0;
        end
        else if (step_en)
        begin
            phase_reg      <= phase_next;
            turn_cw_reg    <= turn_cw_next;
            mode_reg       <= mode_next;
            pending_reg    <= pending_next;
            step_reg       <= step_next;
            poll_reg       <= poll_next;
            revs_reg       <= revs_next;
            delay_left_reg <= delay_left_next;
            coil_reg       <= coil_next;
        end
    end

    always_comb
    begin
        res.coil_pattern  = coil_next;
        res.busy_res      = (mode_next != MODE_IDLE);
        res.accepted      = acc;
        res.done_res      = done;
        res.stopped_early = early;
    end

endmodule

`default_nettype wire

[hw/rtl/shd_chk.sv]
`timescale 1ns / 1ps
`default_nettype none

module shd_chk
    import shd_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_stall,
    input wire logic      out_valid,
    input wire logic      out_stall,
    input wire out_item_t out_item
);

    // A stalled result stays offered and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
        else $error("stalled result changed or dropped");

    // The input backs up only behind a result that the receiver holds off.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled with no waiting result");

    // A taken open or close request always leaves the drive running.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.accepted |-> out_item.busy_res)
        else $error("accepted request without a running drive");

    // A stop ends the run in the same request.
    a_stop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.stopped_early |-> !out_item.busy_res)
        else $error("early stop left the drive running");

    // Each request answers as at most one kind of event.
    a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $countones({out_item.accepted, out_item.done_res,
                                  out_item.stopped_early}) <= 1)
        else $error("more than one event flag in one result");

endmodule

bind stepper_halfstep_door_drive shd_chk u_shd_chk
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
);

`default_nettype wire

[sim/tb_stepper_halfstep_door_drive.sv]
`timescale 1ns / 1ps

module tb_stepper_halfstep_door_drive;
    import shd_pkg::*;

    localparam int unsigned HALF_PERIOD      = 10;
    localparam int unsigned RESET_CYCLES     = 7;
    localparam int unsigned MAX_GAP          = 10;
    localparam int unsigned LONG_HOLD_CYCLES = 300;
    localparam int unsigned RANDOM_ITEMS     = 1650;
    localparam int unsigned BURST_CAP        = 300;
    localparam int unsigned DRAIN_CYCLES     = 4;
    localparam int unsigned POLL_EVERY       = POLL_LAST + 1;

    // Mirror of the sequencer: register copies, drive state and the coil reports
    // it predicts, oldest first.
    class sequencer_mirror;
        logic [9:0]  full_duration;
        logic [7:0]  rev_limit;
        logic [15:0] steps_per_rev;
        logic        open_cw;
        logic        close_cw;
        logic [31:0] phase_tbl;

        logic [2:0]  phase;
        logic        turn_cw;
        logic [1:0]  run_mode;
        logic        pending;
        logic [15:0] step_in_rev;
        logic [7:0]  revs_done;
        logic [4:0]  delay_left;
        logic [3:0]  coil_hold;

        out_item_t   coil_reports[$];
        int unsigned reports_seen;
        int unsigned mismatches;
        int unsigned stray_reports;
        int unsigned reported;
        int unsigned runs_started;
        int unsigned early_stops;
        int unsigned runs_finished;
        int unsigned steps_taken;

        function new();
            full_duration = RST_FULL_DURATION;
            rev_limit     = RST_REVOLUTION_LIM;
            steps_per_rev = RST_STEPS_PER_REV;
            open_cw       = RST_OPEN_CW;
            close_cw      = RST_CLOSE_CW;
            phase_tbl     = RST_PHASE_TABLE;
            phase         = '0;
            turn_cw       = 1'b0;
            run_mode      = MODE_IDLE;
            pending       = 1'b0;
            step_in_rev   = '0;
            revs_done     = '0;
            delay_left    = '0;
            coil_hold     = '0;
            reports_seen  = 0;
            mismatches    = 0;
            stray_reports = 0;
            reported      = 0;
            runs_started  = 0;
            early_stops   = 0;
            runs_finished = 0;
            steps_taken   = 0;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_FULL_DURATION:   full_duration = data[9:0];
                CFG_REVOLUTION_LIM:  rev_limit     = data[7:0];
                CFG_STEPS_PER_REV:   steps_per_rev = data[15:0];
                CFG_OPEN_CLOCKWISE:  open_cw       = data[0];
                CFG_CLOSE_CLOCKWISE: close_cw      = data[0];
                CFG_PHASE_TABLE:     phase_tbl     = data;
                default:             ;
            endcase
        endfunction

        function int unsigned step_delay_ms();
            int unsigned d;
            int unsigned us;
            d = (full_duration > DURATION_MAX) ? DURATION_FALLBACK : full_duration;
            // Microseconds per step: d seconds spread over 12 turns of 4096 steps.
            us = d * 1000000 / 49152;
            return (us <= 1000) ? 1 : us / 1000;
        endfunction

        // Applies one request and queues the report it causes. Returns 1 when the
        // request did something, as opposed to a tick while idle or a refused request.
        function bit take_request(input in_item_t req);
            out_item_t   res;
            bit          effective;
            int unsigned idx;
            res       = '0;
            effective = 1'b0;
            case (req.opcode)
                OP_OPEN, OP_CLOSE:
                begin
                    if (run_mode == MODE_IDLE)
                    begin
                        turn_cw     = (req.opcode == OP_OPEN) ? open_cw : close_cw;
                        run_mode    = (req.opcode == OP_OPEN) ? MODE_OPENING : MODE_CLOSING;
                        pending     = 1'b1;
                        step_in_rev = '0;
                        revs_done   = '0;
                        delay_left  = '0;
                        res.accepted = 1'b1;
                        effective   = 1'b1;
                        runs_started++;
                    end
                end
                OP_QUERY:
                begin
                    effective = 1'b1;
                    if (!pending)
                    begin
                        res.done_res = 1'b1;
                    end
                    else if (run_mode == MODE_IDLE)
                    begin
                        pending      = 1'b0;
                        res.done_res = 1'b1;
                    end
                end
                default:
                begin
                    if (run_mode != MODE_IDLE)
                    begin
                        effective = 1'b1;
                        if (delay_left != 0)
                        begin
                            delay_left = delay_left - 5'd1;
                        end
                        else if (revs_done >= rev_limit || steps_per_rev == 0)
                        begin
                            run_mode   = MODE_IDLE;
                            delay_left = '0;
                            runs_finished++;
                        end
                        else
                        begin
                            // The coils show the pattern of the phase before it moves.
                            idx       = step_in_rev;
                            coil_hold = phase_tbl[{phase, 2'b00} +: 4];
                            phase     = turn_cw ? phase - 3'd1 : phase + 3'd1;
                            steps_taken++;
                            if ((idx % POLL_EVERY) == 0 && req.stop_level)
                            begin
                                res.stopped_early = 1'b1;
                                run_mode   = MODE_IDLE;
                                delay_left = '0;
                                early_stops++;
                            end
                            else
                            begin
                                idx++;
                                if (idx >= steps_per_rev)
                                begin
                                    step_in_rev = '0;
                                    revs_done   = revs_done + 8'd1;
                                end
                                else
                                begin
                                    step_in_rev = idx[15:0];
                                end
                                delay_left = 5'(step_delay_ms() - 1);
                            end
                        end
                    end
                end
            endcase
            res.coil_pattern = coil_hold;
            res.busy_res     = (run_mode != MODE_IDLE);
            coil_reports.push_back(res);
            return effective;
        endfunction

        function void match_report(input out_item_t got);
            out_item_t want;
            reports_seen++;
            if (coil_reports.size() == 0)
            begin
                stray_reports++;
                reported++;
                if (reported <= 10)
                    $display("[%0t] result with no request behind it: %s%h %s%b %s%b %s%b %s%b",
                             $realtime, "coil=", got.coil_pattern, "busy=", got.busy_res,
                             "acc=", got.accepted, "done=", got.done_res,
                             "early=", got.stopped_early);
                return;
            end
            want = coil_reports.pop_front();
            if (got.coil_pattern !== want.coil_pattern || got.busy_res !== want.busy_res ||
                got.accepted !== want.accepted || got.done_res !== want.done_res ||
                got.stopped_early !== want.stopped_early)
            begin
                mismatches++;
                reported++;
                if (reported <= 10)
                begin
                    $display("[%0t] result %0d differs:", $realtime, reports_seen);
                    $display("    expected coil=%h busy=%b acc=%b done=%b early=%b",
                             want.coil_pattern, want.busy_res, want.accepted,
                             want.done_res, want.stopped_early);
                    $display("    actual   coil=%h busy=%b acc=%b done=%b early=%b",
                             got.coil_pattern, got.busy_res, got.accepted,
                             got.done_res, got.stopped_early);
                end
            end
        endfunction

        function int unsigned error_count();
            return mismatches + stray_reports + coil_reports.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_item_t              in_item;
    logic                  out_valid;
    logic                  out_stall;
    out_item_t             out_item;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    sequencer_mirror mirror;
    bit              calm;
    bit              long_hold;
    int unsigned     effective_items;

    stepper_halfstep_door_drive dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #(HALF_PERIOD) clk = ~clk;
    end

    initial
    begin : watchdog
        #(20_000_000);
        $display("DONE: errors detected");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            mirror.match_report(out_item);
    end

    // Result side: a random hold-off before each result, none in calm stretches,
    // and one long hold-off when asked for.
    initial
    begin : receiver
        int unsigned n;
        out_stall <= 1'b0;
        forever
        begin
            if (long_hold)
                n = LONG_HOLD_CYCLES;
            else if (calm)
                n = 0;
            else
                n = $urandom_range(0, MAX_GAP);
            long_hold = 1'b0;
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    task automatic offer(input logic [1:0] op, input logic stop);
        in_item_t    req;
        int unsigned gap;
        req.opcode     = op;
        req.stop_level = stop;
        gap = calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= req;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        void'(mirror.take_request(req));
        effective_items++;
    endtask

    // Stops offering and waits until every predicted result has come back.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (mirror.coil_reports.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        mirror.write_reg(idx, data);
    endtask

    task automatic program_regs(input logic [9:0] dur, input logic [7:0] lim,
                                input logic [15:0] spr, input logic ocw, input logic ccw,
                                input logic [31:0] tbl);
        write_reg(CFG_FULL_DURATION, CFG_DATA_W'(dur));
        write_reg(CFG_REVOLUTION_LIM, CFG_DATA_W'(lim));
        write_reg(CFG_STEPS_PER_REV, CFG_DATA_W'(spr));
        write_reg(CFG_OPEN_CLOCKWISE, CFG_DATA_W'(ocw));
        write_reg(CFG_CLOSE_CLOCKWISE, CFG_DATA_W'(ccw));
        write_reg(CFG_PHASE_TABLE, tbl);
        cfg_we <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [9:0]  dur;
        logic [7:0]  lim;
        logic [15:0] spr;
        logic [31:0] tbl;
        logic        stop;
        longint unsigned est;
        int unsigned burst;
        int unsigned stop_pct;
        int unsigned target;
        int unsigned phase_no;
        bit          late_stop;

        mirror          = new();
        calm            = 1'b0;
        long_hold       = 1'b0;
        effective_items = 0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_item   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_FULL_DURATION;
        cfg_data  <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default registers: queries with nothing pending, an idle tick, refused
        // requests while busy, and a stop seen on the very first step.
        offer(OP_QUERY, 1'b0);
        offer(OP_TICK, 1'b1);
        offer(OP_OPEN, 1'b1);
        offer(OP_CLOSE, 1'b0);
        offer(OP_OPEN, 1'b0);
        offer(OP_QUERY, 1'b1);
        offer(OP_TICK, 1'b1);
        offer(OP_QUERY, 1'b0);
        offer(OP_QUERY, 1'b0);
        offer(OP_CLOSE, 1'b0);
        offer(OP_TICK, 1'b0);
        offer(OP_TICK, 1'b0);
        offer(OP_TICK, 1'b1);
        settle();

        // A zero revolution limit ends a run on its first tick.
        program_regs(10'd1023, 8'd0, 16'd4096, 1'b1, 1'b0, 32'hFFFF_FFFF);
        offer(OP_TICK, 1'b0);
        offer(OP_QUERY, 1'b0);
        offer(OP_OPEN, 1'b0);
        offer(OP_TICK, 1'b0);
        settle();

        // Zero steps per revolution also ends the run without a step.
        program_regs(10'd0, 8'd1, 16'd0, 1'b0, 1'b1, 32'h0123_4567);
        offer(OP_CLOSE, 1'b0);
        offer(OP_TICK, 1'b0);
        offer(OP_QUERY, 1'b0);
        settle();

        // Longest step delay.
        program_regs(10'd1000, 8'd1, 16'd2, 1'b0, 1'b0, 32'h0000_0000);
        offer(OP_OPEN, 1'b0);
        offer(OP_TICK, 1'b0);
        offer(OP_TICK, 1'b0);
        offer(OP_QUERY, 1'b0);

        effective_items = 0;
        phase_no        = 0;
        while (effective_items < RANDOM_ITEMS)
        begin
            settle();
            calm = 1'b0;
            case ($urandom_range(0, 5))
                0:       dur = 10'd0;
                1:       dur = 10'd1023;
                2:       dur = 10'd1000;
                3:       dur = 10'($urandom_range(0, 1023));
                default: dur = 10'($urandom_range(0, 98));
            endcase
            case ($urandom_range(0, 7))
                0:       lim = 8'd0;
                1:       lim = 8'd255;
                default: lim = 8'($urandom_range(1, 3));
            endcase
            case ($urandom_range(0, 9))
                0:       spr = 16'd0;
                1:       spr = 16'd65535;
                2, 3:    spr = 16'($urandom_range(125, 140));
                default: spr = 16'($urandom_range(1, 6));
            endcase
            case ($urandom_range(0, 5))
                0:       tbl = 32'h0000_0000;
                1:       tbl = 32'hFFFF_FFFF;
                default: tbl = $urandom;
            endcase
            program_regs(dur, lim, spr, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), tbl);

            calm = ($urandom_range(0, 3) == 0);
            if (phase_no == 2)
            begin
                // Keep offering while the result side holds off, so the block backs up.
                calm      = 1'b1;
                long_hold = 1'b1;
            end
            late_stop = ($urandom_range(0, 3) == 0);
            stop_pct  = $urandom_range(0, 4);
            est = longint'(spr) * lim * mirror.step_delay_ms() + 3;
            if (est > BURST_CAP)
                est = BURST_CAP;
            target = effective_items + $urandom_range(80, 160);

            while (effective_items < target)
            begin
                if ($urandom_range(0, 99) < 12)
                begin
                    offer(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
                end
                else
                begin
                    offer(($urandom_range(0, 1) == 1) ? OP_OPEN : OP_CLOSE,
                          1'($urandom_range(0, 1)));
                    burst = $urandom_range(1, int'(est));
                    for (int k = 0; k < burst; k++)
                    begin
                        // A late stop stays low past the first poll and can catch a later one.
                        if (late_stop)
                            stop = (k >= 100);
                        else
                            stop = ($urandom_range(0, 99) < stop_pct);
                        if ($urandom_range(0, 99) < 6)
                            offer(OP_QUERY, stop);
                        else
                            offer(OP_TICK, stop);
                    end
                    offer(OP_QUERY, 1'($urandom_range(0, 1)));
                end
            end
            phase_no++;
        end

        calm = 1'b0;
        settle();

        $display("Ran %0d register settings: %0d runs started, %0d stopped early,",
                 phase_no + 4, mirror.runs_started, mirror.early_stops);
        $display("%0d ran to the end, %0d coil steps and %0d results checked.",
                 mirror.runs_finished, mirror.steps_taken, mirror.reports_seen);
        if (mirror.error_count() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
